### rtl/core/qph_pkg.sv
// Shared types and constants for the quadratic probe hash table.
// Holds the payload structs, operation and result codes, and the
// controller/datapath command and status structs. No dependencies.
package qph_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    RES_INSERTED  = 3'd0,
    RES_DUP_REJ   = 3'd1,
    RES_DUP_KEEP  = 3'd2,
    RES_FULL      = 3'd3,
    RES_FOUND     = 3'd4,
    RES_NOT_FOUND = 3'd5,
    RES_DELETED   = 3'd6,
    RES_DEL_MISS  = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_LIVE  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_st_e;

  localparam logic [10:0] SIZE_RESET     = 11'd1021;
  localparam logic        REG_TABLE_SIZE = 1'b0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_value;
    logic [10:0] live_count;
    logic [10:0] tombstone_count;
  } out_t;

  typedef struct packed {
    logic    load_op;
    logic    work_from_op;
    logic    work_from_snap;
    logic    mod_start;
    logic    mod_step;
    logic    probe_init;
    logic    probe_next;
    logic    slot_rd_probe;
    logic    slot_rd_idx;
    logic    snap_rd;
    logic    snap_wr;
    logic    slot_clr_wr;
    logic    slot_live_wr;
    logic    slot_tomb_wr;
    logic    idx_clear;
    logic    idx_inc;
    logic    cnt_clear;
    logic    res_load;
    logic    res_hit;
    status_e res_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    mod_done;
    logic    st_live;
    logic    st_empty;
    logic    key_eq;
    logic    val_eq;
    logic    tomb_avail;
    logic    probe_last;
    logic    snap_live;
    logic    idx_last;
    logic    clr_last;
    logic    sweep_need;
    logic    out_free;
  } sts_t;

endpackage

### rtl/core/qph_ram.sv
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered. No dependencies.
module qph_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/qph_ctrl.sv
// Controller state machine of the quadratic probe hash table.
// Depends on qph_pkg for the command and status structs.
module qph_ctrl import qph_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_MOD, S_PINIT, S_RD, S_CHK, S_DONE,
    S_CPRD, S_CPWR, S_RERD, S_RECHK, S_RENEXT
  } state_e;

  state_e state_q, state_d;
  logic   reins_q, reins_d;
  logic   ins_mode;
  logic   hit;

  assign ins_mode   = reins_q || (sts_i.op == OP_INSERT);
  assign hit        = sts_i.st_live && sts_i.key_eq;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    reins_d = reins_q;
    unique case (state_q)
      S_CLR: begin
        cmd_o.slot_clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.idx_clear = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_op = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.op == OP_NONE) begin
          cmd_o.res_code = RES_NOT_FOUND;
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
        end else if (sts_i.op != OP_QUERY && sts_i.sweep_need) begin
          cmd_o.idx_clear = 1'b1;
          state_d         = S_CPRD;
        end else begin
          cmd_o.work_from_op = 1'b1;
          cmd_o.mod_start    = 1'b1;
          state_d            = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_done) begin
          state_d = S_PINIT;
        end
      end
      S_PINIT: begin
        cmd_o.probe_init = 1'b1;
        state_d          = S_RD;
      end
      S_RD: begin
        cmd_o.slot_rd_probe = 1'b1;
        state_d             = S_CHK;
      end
      S_CHK: begin
        if (ins_mode) begin
          if (hit) begin
            cmd_o.res_code = sts_i.val_eq ? RES_DUP_REJ : RES_DUP_KEEP;
            cmd_o.res_load = 1'b1;
          end else if (sts_i.st_empty || (sts_i.probe_last && sts_i.tomb_avail)) begin
            cmd_o.slot_live_wr = 1'b1;
            cmd_o.res_code     = RES_INSERTED;
            cmd_o.res_load     = 1'b1;
          end else if (sts_i.probe_last) begin
            cmd_o.res_code = RES_FULL;
            cmd_o.res_load = 1'b1;
          end else begin
            cmd_o.probe_next = 1'b1;
          end
        end else if (sts_i.op == OP_QUERY) begin
          if (hit) begin
            cmd_o.res_code = RES_FOUND;
            cmd_o.res_hit  = 1'b1;
            cmd_o.res_load = 1'b1;
          end else if (sts_i.st_empty || sts_i.probe_last) begin
            cmd_o.res_code = RES_NOT_FOUND;
            cmd_o.res_load = 1'b1;
          end else begin
            cmd_o.probe_next = 1'b1;
          end
        end else begin
          if (hit) begin
            cmd_o.slot_tomb_wr = 1'b1;
            cmd_o.res_code     = RES_DELETED;
            cmd_o.res_load     = 1'b1;
          end else if (sts_i.st_empty || sts_i.probe_last) begin
            cmd_o.res_code = RES_DEL_MISS;
            cmd_o.res_load = 1'b1;
          end else begin
            cmd_o.probe_next = 1'b1;
          end
        end
        if (cmd_o.probe_next) begin
          state_d = S_RD;
        end else if (reins_q) begin
          // Reinserted entries produce no result.
          cmd_o.res_load = 1'b0;
          state_d        = S_RENEXT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_CPRD: begin
        cmd_o.slot_rd_idx = 1'b1;
        state_d           = S_CPWR;
      end
      S_CPWR: begin
        cmd_o.snap_wr     = 1'b1;
        cmd_o.slot_clr_wr = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.idx_clear = 1'b1;
          cmd_o.cnt_clear = 1'b1;
          state_d         = S_RERD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_CPRD;
        end
      end
      S_RERD: begin
        cmd_o.snap_rd = 1'b1;
        state_d       = S_RECHK;
      end
      S_RECHK: begin
        if (sts_i.snap_live) begin
          cmd_o.work_from_snap = 1'b1;
          cmd_o.mod_start      = 1'b1;
          reins_d              = 1'b1;
          state_d              = S_MOD;
        end else begin
          state_d = S_RENEXT;
        end
      end
      S_RENEXT: begin
        if (sts_i.idx_last) begin
          cmd_o.work_from_op = 1'b1;
          cmd_o.mod_start    = 1'b1;
          reins_d            = 1'b0;
          state_d            = S_MOD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_RERD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      reins_q <= 1'b0;
    end else begin
      state_q <= state_d;
      reins_q <= reins_d;
    end
  end

endmodule

### rtl/core/qph_dp.sv
// Datapath of the quadratic probe hash table: operand registers, remainder
// unit, probe address stepper, counters and result register. Uses qph_pkg.
module qph_dp import qph_pkg::*; #(
  parameter int DEPTH       = 1024,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int DW = 2 + KEY_WIDTH + VALUE_WIDTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  output sts_t          sts_o,
  input  logic [CW-1:0] n_i,
  input  in_t           in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output out_t          out_data_o,
  output logic [CW-1:0] live_o,
  output logic [CW-1:0] tomb_o,
  output logic          slot_we_o,
  output logic [AW-1:0] slot_waddr_o,
  output logic [DW-1:0] slot_wdata_o,
  output logic          slot_re_o,
  output logic [AW-1:0] slot_raddr_o,
  input  logic [DW-1:0] slot_rdata_i,
  output logic          snap_we_o,
  output logic [AW-1:0] snap_waddr_o,
  output logic [DW-1:0] snap_wdata_o,
  output logic          snap_re_o,
  output logic [AW-1:0] snap_raddr_o,
  input  logic [DW-1:0] snap_rdata_i
);

  localparam int MOD_STEPS = (KEY_WIDTH + 3) / 4;
  localparam int MW        = MOD_STEPS * 4;
  localparam int MCW       = $clog2(MOD_STEPS);
  localparam int SW        = CW + 3;

  logic [1:0]             op_q;
  logic [KEY_WIDTH-1:0]   okey_q, wk_q, wk_d;
  logic [VALUE_WIDTH-1:0] oval_q, wv_q, wv_d, vin;
  logic [VALUE_WIDTH+31:0] vin_ext, rv_ext;
  logic [MW-1:0]          mq_q, mq_nxt;
  logic [CW-1:0]          rem_q, rem_nxt;
  logic [MCW-1:0]         mcnt_q;
  logic [AW-1:0]          s_q, s_nxt, tomb_at_q, idx_q, target;
  logic [CW-1:0]          i_q, n_m1;
  logic                   have_tomb_q;
  logic [CW-1:0]          live_q, tomb_q;
  status_e                res_code_q;
  logic [VALUE_WIDTH-1:0] res_rv_q;
  logic                   out_valid_q;
  out_t                   out_q;
  slot_st_e               slot_st, snap_st;
  logic [KEY_WIDTH-1:0]   slot_key;
  logic [VALUE_WIDTH-1:0] slot_val, snap_val;
  logic [KEY_WIDTH-1:0]   snap_key;
  logic [CW+1:0]          psum, psub1, psub2, n_ext;
  logic [SW-1:0]          occ4, n3, tomb3;
  logic                   tomb_avail;

  assign vin_ext = {{VALUE_WIDTH{1'b0}}, in_data_i.value};
  assign vin     = vin_ext[VALUE_WIDTH-1:0];

  assign slot_st  = slot_st_e'(slot_rdata_i[DW-1 -: 2]);
  assign slot_key = slot_rdata_i[VALUE_WIDTH +: KEY_WIDTH];
  assign slot_val = slot_rdata_i[0 +: VALUE_WIDTH];
  assign snap_st  = slot_st_e'(snap_rdata_i[DW-1 -: 2]);
  assign snap_key = snap_rdata_i[VALUE_WIDTH +: KEY_WIDTH];
  assign snap_val = snap_rdata_i[0 +: VALUE_WIDTH];

  // Working operands come either from the accepted operation or from a
  // snapshot entry being reinserted.
  always_comb begin
    wk_d = wk_q;
    wv_d = wv_q;
    if (cmd_i.work_from_op) begin
      wk_d = okey_q;
      wv_d = oval_q;
    end else if (cmd_i.work_from_snap) begin
      wk_d = snap_key;
      wv_d = snap_val;
    end
  end

  // Restoring remainder, four key bits per cycle.
  always_comb begin
    logic [CW:0] t;
    rem_nxt = rem_q;
    mq_nxt  = mq_q;
    for (int k = 0; k < 4; k++) begin
      t      = {rem_nxt, mq_nxt[MW-1]};
      mq_nxt = {mq_nxt[MW-2:0], 1'b0};
      if (t >= {1'b0, n_i}) begin
        t = t - {1'b0, n_i};
      end
      rem_nxt = t[CW-1:0];
    end
  end

  // Next probe slot: s + 2i + 1, folded back below n.
  assign n_ext = (CW + 2)'(n_i);
  assign psum  = (CW + 2)'(s_q) + (CW + 2)'({i_q, 1'b1});
  assign psub1 = (psum >= n_ext) ? psum - n_ext : psum;
  assign psub2 = (psub1 >= n_ext) ? psub1 - n_ext : psub1;
  assign s_nxt = AW'(psub2);
  assign n_m1  = n_i - CW'(1);

  assign tomb_avail = have_tomb_q || (slot_st == ST_TOMB);
  assign target     = have_tomb_q ? tomb_at_q : s_q;

  assign occ4  = (SW'(live_q) + SW'(tomb_q)) << 2;
  assign n3    = SW'(n_i) + (SW'(n_i) << 1);
  assign tomb3 = SW'(tomb_q) + (SW'(tomb_q) << 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      op_q   <= in_data_i.opcode;
      okey_q <= in_data_i.key[KEY_WIDTH-1:0];
      oval_q <= vin;
    end
    wk_q <= wk_d;
    wv_q <= wv_d;
    if (cmd_i.mod_start) begin
      mq_q   <= MW'(wk_d);
      rem_q  <= '0;
      mcnt_q <= '0;
    end else if (cmd_i.mod_step) begin
      mq_q   <= mq_nxt;
      rem_q  <= rem_nxt;
      mcnt_q <= mcnt_q + MCW'(1);
    end
    if (cmd_i.probe_init) begin
      s_q         <= AW'(rem_q);
      i_q         <= '0;
      have_tomb_q <= 1'b0;
    end else if (cmd_i.probe_next) begin
      if (!have_tomb_q && slot_st == ST_TOMB) begin
        have_tomb_q <= 1'b1;
        tomb_at_q   <= s_q;
      end
      s_q <= s_nxt;
      i_q <= i_q + CW'(1);
    end
    if (cmd_i.res_load) begin
      res_code_q <= cmd_i.res_code;
      res_rv_q   <= cmd_i.res_hit ? slot_val : '0;
    end
    if (cmd_i.out_load) begin
      out_q.status          <= res_code_q;
      out_q.read_value      <= rv_ext[31:0];
      out_q.live_count      <= 11'(live_q);
      out_q.tombstone_count <= 11'(tomb_q);
    end
  end

  assign rv_ext = {32'b0, res_rv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      live_q      <= '0;
      tomb_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.idx_clear) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + AW'(1);
      end
      if (cmd_i.cnt_clear) begin
        live_q <= '0;
        tomb_q <= '0;
      end else if (cmd_i.slot_live_wr) begin
        live_q <= live_q + CW'(1);
        if (tomb_avail) begin
          tomb_q <= tomb_q - CW'(1);
        end
      end else if (cmd_i.slot_tomb_wr) begin
        live_q <= live_q - CW'(1);
        tomb_q <= tomb_q + CW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Memory ports.
  always_comb begin
    slot_we_o    = cmd_i.slot_clr_wr || cmd_i.slot_live_wr || cmd_i.slot_tomb_wr;
    slot_waddr_o = idx_q;
    slot_wdata_o = {ST_EMPTY, wk_q, wv_q};
    if (cmd_i.slot_live_wr) begin
      slot_waddr_o = target;
      slot_wdata_o = {ST_LIVE, wk_q, wv_q};
    end else if (cmd_i.slot_tomb_wr) begin
      slot_waddr_o = s_q;
      slot_wdata_o = {ST_TOMB, slot_key, slot_val};
    end
  end

  assign slot_re_o    = cmd_i.slot_rd_probe || cmd_i.slot_rd_idx;
  assign slot_raddr_o = cmd_i.slot_rd_probe ? s_q : idx_q;
  assign snap_we_o    = cmd_i.snap_wr;
  assign snap_waddr_o = idx_q;
  assign snap_wdata_o = slot_rdata_i;
  assign snap_re_o    = cmd_i.snap_rd;
  assign snap_raddr_o = idx_q;

  always_comb begin
    sts_o            = '0;
    sts_o.op         = opcode_e'(op_q);
    sts_o.mod_done   = (mcnt_q == MCW'(MOD_STEPS - 1));
    sts_o.st_live    = (slot_st == ST_LIVE);
    sts_o.st_empty   = (slot_st == ST_EMPTY);
    sts_o.key_eq     = (slot_key == wk_q);
    sts_o.val_eq     = (slot_val == wv_q);
    sts_o.tomb_avail = tomb_avail;
    sts_o.probe_last = (i_q == n_m1);
    sts_o.snap_live  = (snap_st == ST_LIVE);
    sts_o.idx_last   = (CW'(idx_q) == n_m1);
    sts_o.clr_last   = (idx_q == AW'(DEPTH - 1));
    sts_o.sweep_need = (occ4 > n3) && (tomb3 > SW'(live_q));
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign live_o      = live_q;
  assign tomb_o      = tomb_q;

endmodule

### rtl/core/quadratic_probe_hash_table.sv
// Top level of the quadratic probe hash table: configuration register,
// controller, datapath and the slot and snapshot memories.
// Depends on qph_pkg, qph_ram, qph_ctrl and qph_dp.
//
// Usage. Operations (insert, query, delete) arrive as transactions on the
// in_valid_i/in_ready_o channel; each produces exactly one result
// transaction on out_valid_o/out_ready_i carrying a status code, the
// value found by a query, and the live and tombstone counts afterwards.
// The table_size register sits at APB address 0; a write is ignored while
// the table holds any live or tombstoned slot, and reads return it.
//
// Operation flow. One operation is in flight at a time. Each operation
// first reduces its key to a remainder and then visits its probes: the key
// remainder unit retires four key bits per cycle, and each probe is one
// read plus one compare over the single slot memory read port. When an
// insert or delete finds the table crowded with tombstones, a rebuild runs
// first: each of the n slots is copied to the snapshot and cleared, then
// each snapshot slot is read and checked, with a full insert for live ones.
//
// Reset clears all DEPTH slots of the slot memory in a pass during which
// in_ready_o stays low. A stalled receiver only holds the output
// register; the next operation is still accepted and runs up to its
// result, which then waits until the output register is free.
module quadratic_probe_hash_table import qph_pkg::*; #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32,
  parameter int KEY_WIDTH   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = 2 + KEY_WIDTH + VALUE_WIDTH;

  logic [10:0]   size_q;
  logic [CW-1:0] n;
  logic [CW-1:0] live, tomb;
  logic          cfg_wr;
  cmd_t          cmd;
  sts_t          sts;

  logic          slot_we, slot_re, snap_we, snap_re;
  logic [AW-1:0] slot_waddr, slot_raddr, snap_waddr, snap_raddr;
  logic [DW-1:0] slot_wdata, slot_rdata, snap_wdata, snap_rdata;

  // The register only takes a new size while the table is fully empty.
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TABLE_SIZE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TABLE_SIZE) ? 32'(size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_wr && live == '0 && tomb == '0) begin
      size_q <= pwdata[10:0];
    end
  end

  // Effective size is the register clamped into 1..DEPTH.
  always_comb begin
    if (size_q == '0) begin
      n = CW'(1);
    end else if (32'(size_q) > DEPTH) begin
      n = CW'(DEPTH);
    end else begin
      n = CW'(size_q);
    end
  end

  qph_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qph_dp #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .n_i          (n),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .live_o       (live),
    .tomb_o       (tomb),
    .slot_we_o    (slot_we),
    .slot_waddr_o (slot_waddr),
    .slot_wdata_o (slot_wdata),
    .slot_re_o    (slot_re),
    .slot_raddr_o (slot_raddr),
    .slot_rdata_i (slot_rdata),
    .snap_we_o    (snap_we),
    .snap_waddr_o (snap_waddr),
    .snap_wdata_o (snap_wdata),
    .snap_re_o    (snap_re),
    .snap_raddr_o (snap_raddr),
    .snap_rdata_i (snap_rdata)
  );

  // Each slot word holds its state, key and value side by side.
  qph_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // Snapshot of the table taken at the start of a rebuild.
  qph_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_snap_ram (
    .clk_i   (clk_i),
    .we_i    (snap_we),
    .waddr_i (snap_waddr),
    .wdata_i (snap_wdata),
    .re_i    (snap_re),
    .raddr_i (snap_raddr),
    .rdata_o (snap_rdata)
  );

  // Only one operation may be in flight: acceptance drops ready.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second operation accepted while one is in flight");

  // Occupied slots can never exceed the effective table size.
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CW + 1)'(live) + (CW + 1)'(tomb)) <= (CW + 1)'(n))
    else $error("live plus tombstone count exceeds table size");

  // A size write is dropped while the table is occupied.
  a_size_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (live != '0 || tomb != '0)) |=> $stable(size_q))
    else $error("table size changed while table occupied");

endmodule

### verif/tb_quadratic_probe_hash_table.sv
// Self-checking testbench for the quadratic probe hash table.
// Drives operation transactions and APB writes of table_size, predicts every
// result with a behavioral table model. Depends on qph_pkg and the RTL top.
module tb_quadratic_probe_hash_table;
  import qph_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  quadratic_probe_hash_table dut (.*);

  always #10 clk_i = ~clk_i;

  // Predictor state: a shadow copy of the slot table and its counters.
  slot_st_e    shadow_state [TBL_DEPTH];
  logic [31:0] shadow_key   [TBL_DEPTH];
  logic [31:0] shadow_val   [TBL_DEPTH];
  int unsigned shadow_live;
  int unsigned shadow_tombs;
  logic [10:0] shadow_size;

  out_t        pending_results [$];
  logic [31:0] known_keys [$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  function automatic int unsigned slots_in_use();
    if (shadow_size < 1) return 1;
    if (shadow_size > TBL_DEPTH) return TBL_DEPTH;
    return shadow_size;
  endfunction

  function automatic int unsigned probe_index(logic [31:0] key, int unsigned i,
                                              int unsigned n);
    longint unsigned sum;
    sum = longint'(key) + longint'(i) * longint'(i);
    return int'(sum % n);
  endfunction

  function automatic status_e table_insert(logic [31:0] key, logic [31:0] val);
    int unsigned n, i, s, tomb_at;
    bit have_tomb;
    n = slots_in_use();
    have_tomb = 0;
    tomb_at = 0;
    for (i = 0; i < n; i++) begin
      s = probe_index(key, i, n);
      if (shadow_state[s] == ST_LIVE && shadow_key[s] == key)
        return (shadow_val[s] == val) ? RES_DUP_REJ : RES_DUP_KEEP;
      if (!have_tomb && shadow_state[s] == ST_TOMB) begin
        have_tomb = 1;
        tomb_at = s;
      end
      if (shadow_state[s] == ST_EMPTY) break;
    end
    if (i < n || have_tomb) begin
      s = have_tomb ? tomb_at : probe_index(key, i, n);
      if (have_tomb) shadow_tombs--;
      shadow_state[s] = ST_LIVE;
      shadow_key[s] = key;
      shadow_val[s] = val;
      shadow_live++;
      return RES_INSERTED;
    end
    return RES_FULL;
  endfunction

  // Rebuild when the table is crowded and tombstones are a large share.
  function automatic void rebuild_if_crowded();
    int unsigned n;
    slot_st_e    old_state [TBL_DEPTH];
    logic [31:0] old_key   [TBL_DEPTH];
    logic [31:0] old_val   [TBL_DEPTH];
    status_e     ignored;
    n = slots_in_use();
    if ((shadow_live + shadow_tombs) * 4 <= n * 3 || shadow_tombs * 3 <= shadow_live)
      return;
    old_state = shadow_state;
    old_key = shadow_key;
    old_val = shadow_val;
    foreach (shadow_state[j]) shadow_state[j] = ST_EMPTY;
    shadow_live = 0;
    shadow_tombs = 0;
    for (int unsigned j = 0; j < n; j++)
      if (old_state[j] == ST_LIVE) ignored = table_insert(old_key[j], old_val[j]);
  endfunction

  function automatic out_t predict_result(in_t op);
    out_t r;
    int unsigned n, s;
    r = '0;
    r.status = RES_NOT_FOUND;
    n = slots_in_use();
    case (op.opcode)
      OP_INSERT: begin
        rebuild_if_crowded();
        r.status = table_insert(op.key, op.value);
      end
      OP_QUERY: begin
        for (int unsigned i = 0; i < n; i++) begin
          s = probe_index(op.key, i, n);
          if (shadow_state[s] == ST_LIVE && shadow_key[s] == op.key) begin
            r.status = RES_FOUND;
            r.read_value = shadow_val[s];
            break;
          end
          if (shadow_state[s] == ST_EMPTY) break;
        end
      end
      OP_DELETE: begin
        rebuild_if_crowded();
        r.status = RES_DEL_MISS;
        for (int unsigned i = 0; i < n; i++) begin
          s = probe_index(op.key, i, n);
          if (shadow_state[s] == ST_LIVE && shadow_key[s] == op.key) begin
            shadow_state[s] = ST_TOMB;
            shadow_live--;
            shadow_tombs++;
            r.status = RES_DELETED;
            break;
          end
          if (shadow_state[s] == ST_EMPTY) break;
        end
      end
      default: ;
    endcase
    r.live_count = shadow_live[10:0];
    r.tombstone_count = shadow_tombs[10:0];
    return r;
  endfunction

  // Send one operation transaction; the expectation is queued on acceptance.
  // The block drops ready after each acceptance, so waiting for a clock
  // edge before raising valid costs no throughput.
  task automatic send_op(opcode_e opc, logic [31:0] key, logic [31:0] val);
    in_t op;
    op.opcode = opc;
    op.key = key;
    op.value = val;
    do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    in_valid_i <= 1'b1;
    in_data_i <= op;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_result(op));
    if (opc == OP_INSERT) known_keys.push_back(key);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Register writes happen only with the table idle, once every expected
  // result has been drained.
  task automatic write_size(logic [31:0] size);
    wait_drained();
    repeat (20) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {REG_TABLE_SIZE, 2'b00};
    pwdata <= size;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (shadow_live == 0 && shadow_tombs == 0) shadow_size = size[10:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Deleting everything leaves only tombstones; a rebuild then empties it,
  // but stale tombstones may remain, so the size write may be ignored.
  task automatic empty_table();
    while (known_keys.size() != 0) send_op(OP_DELETE, known_keys.pop_front(), '0);
    wait_drained();
  endtask

  function automatic logic [31:0] pick_key();
    if (known_keys.size() != 0 && $urandom_range(2) != 0)
      return known_keys[$urandom_range(known_keys.size() - 1)];
    return $urandom_range(3) == 0 ? $urandom() : $urandom_range(40);
  endfunction

  task automatic random_ops(int count);
    int pick;
    opcode_e opc;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      opc = pick < 45 ? OP_INSERT : pick < 70 ? OP_QUERY : pick < 97 ? OP_DELETE : OP_NONE;
      send_op(opc, pick_key(), $urandom_range(1) ? $urandom() : $urandom_range(3));
    end
  endtask

  // Directed: field extremes, every opcode, duplicates, misses, the unused
  // opcode, and a size write that the occupied table ignores.
  task automatic test_directed();
    send_op(OP_QUERY, 32'h0, '0);
    send_op(OP_DELETE, 32'hFFFF_FFFF, '0);
    send_op(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 32'h0, 32'h0);
    send_op(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 32'hFFFF_FFFF, 32'h1234_5678);
    send_op(OP_QUERY, 32'hFFFF_FFFF, '0);
    send_op(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_DELETE, 32'h0, '0);
    send_op(OP_QUERY, 32'h0, '0);
    send_op(OP_INSERT, 32'h0, 32'hA5A5_5A5A);
    write_size(3);
    send_op(OP_QUERY, 32'h0, '0);
  endtask

  task automatic test_small_table(logic [31:0] size, int count);
    empty_table();
    write_size(size);
    random_ops(count);
  endtask

  task automatic test_pause();
    wait_drained();
    send_op(OP_QUERY, pick_key(), '0);
  endtask

  // Checker: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    out_t expected;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no operation outstanding");
        error_count++;
      end else begin
        expected = pending_results.pop_front();
        if (out_data_o.status !== expected.status) begin
          $error("status: expected %0d, got %0d", expected.status, out_data_o.status);
          error_count++;
        end
        if (out_data_o.read_value !== expected.read_value) begin
          $error("read_value: expected %h, got %h", expected.read_value,
                 out_data_o.read_value);
          error_count++;
        end
        if (out_data_o.live_count !== expected.live_count) begin
          $error("live_count: expected %0d, got %0d", expected.live_count,
                 out_data_o.live_count);
          error_count++;
        end
        if (out_data_o.tombstone_count !== expected.tombstone_count) begin
          $error("tombstone_count: expected %0d, got %0d", expected.tombstone_count,
                 out_data_o.tombstone_count);
          error_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: counts cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    foreach (shadow_state[j]) shadow_state[j] = ST_EMPTY;
    shadow_live = 0;
    shadow_tombs = 0;
    shadow_size = SIZE_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_small_table(1, 12);
    test_small_table(2, 15);
    test_small_table(0, 10);
    test_small_table(7, 40);
    test_pause();
    send_idle_pct = 73;
    test_small_table(11, 50);
    send_idle_pct = 0;
    recv_stall_pct = 73;
    test_small_table(13, 50);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    test_small_table(2047, 30);
    test_small_table(1024, 30);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_small_table(31, 30);
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
